### rtl/core/wfg_pkg.sv
// ----------------------------------------------------------------------------
// wfg_pkg
// Shared types and operation codes for the wait-for graph cycle detector.
// ----------------------------------------------------------------------------
`default_nettype none

package wfg_pkg;

   localparam logic [1:0] OP_ADD   = 2'd0;
   localparam logic [1:0] OP_CHECK = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   typedef struct packed {
      logic [1:0] op;
      logic [4:0] from_node;
      logic [4:0] to_node;
   } req_type;

   typedef struct packed {
      logic       cycle_found;
      logic [1:0] op_done;
   } rsp_type;

   typedef struct packed {
      logic done;
      logic found;
   } srch_stat_type;

endpackage

`default_nettype wire

### rtl/core/wfg_ram.sv
// ----------------------------------------------------------------------------
// wfg_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module wfg_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/core/wfg_matrix.sv
// ----------------------------------------------------------------------------
// wfg_matrix
// Adjacency matrix store: one RAM row per waiting node, with per-row valid
// bits so that a clear empties the whole matrix without writing the RAM.
// ----------------------------------------------------------------------------
`default_nettype none

module wfg_matrix #(
   parameter int NODES = 32,
   localparam int NW = $clog2(NODES)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             clr,
   input  wire logic             rd_en,
   input  wire logic [NW-1:0]    rd_addr,
   output logic      [NODES-1:0] rd_data,
   input  wire logic             wr_en,
   input  wire logic [NW-1:0]    wr_addr,
   input  wire logic [NODES-1:0] wr_data
);

   logic [NODES-1:0] row_vld_ff;
   logic             rd_vld_ff;
   logic [NODES-1:0] ram_q;

   wfg_ram #(
      .WIDTH (NODES),
      .DEPTH (NODES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   always_ff @(posedge clock) begin
      if (reset || clr) begin
         row_vld_ff <= '0;
      end else if (wr_en) begin
         row_vld_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
      end else if (rd_en) begin
         rd_vld_ff <= row_vld_ff[rd_addr];
      end
   end

   // unwritten rows read as empty
   assign rd_data = rd_vld_ff ? ram_q : '0;

endmodule

`default_nettype wire

### rtl/core/wfg_search.sv
// ----------------------------------------------------------------------------
// wfg_search
// Depth-first search engine. Keeps visited and on-path marks in flops and
// the path of ancestors in a stack RAM; re-reads a node's matrix row on
// every return to it.
// ----------------------------------------------------------------------------
`default_nettype none

module wfg_search #(
   parameter int NODES = 32,
   localparam int NW = $clog2(NODES)
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output wfg_pkg::srch_stat_type      stat,
   output logic                        mat_rd_en,
   output logic          [NW-1:0]      mat_rd_addr,
   input  wire logic     [NODES-1:0]   mat_rd_data
);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_ROOT = 4'b0010,
      S_EVAL = 4'b0100,
      S_POP  = 4'b1000
   } srch_state_type;

   srch_state_type   state_ff, state_in;
   logic [NODES-1:0] visited_ff, visited_in;
   logic [NODES-1:0] on_path_ff, on_path_in;
   logic [NW-1:0]    cur_ff, cur_in;
   logic [NW-1:0]    depth_ff, depth_in;

   logic [NODES-1:0] cand;
   logic [NODES-1:0] enc_in;
   logic [NW-1:0]    enc_idx;
   logic             hit;
   logic             stk_wr_en;
   logic             stk_rd_en;
   logic [NW-1:0]    stk_rd_data;

   function automatic logic [NW-1:0] lowest_set(input logic [NODES-1:0] vec);
      logic [NW-1:0] idx;
      idx = '0;
      for (int i = NODES - 1; i >= 0; i--) begin
         if (vec[i]) begin
            idx = NW'(i);
         end
      end
      return idx;
   endfunction

   wfg_ram #(
      .WIDTH (NW),
      .DEPTH (NODES)
   ) u_stack (
      .clock   (clock),
      .wr_en   (stk_wr_en),
      .wr_addr (depth_ff),
      .wr_data (cur_ff),
      .rd_en   (stk_rd_en),
      .rd_addr (depth_ff - NW'(1)),
      .rd_data (stk_rd_data)
   );

   assign cand    = mat_rd_data & ~visited_ff;
   assign hit     = |(mat_rd_data & on_path_ff);
   assign enc_in  = (state_ff == S_ROOT) ? ~visited_ff : cand;
   assign enc_idx = lowest_set(enc_in);

   always_comb begin
      state_in    = state_ff;
      visited_in  = visited_ff;
      on_path_in  = on_path_ff;
      cur_in      = cur_ff;
      depth_in    = depth_ff;
      stk_wr_en   = 1'b0;
      stk_rd_en   = 1'b0;
      mat_rd_en   = 1'b0;
      mat_rd_addr = cur_ff;
      stat        = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               visited_in = '0;
               on_path_in = '0;
               depth_in   = '0;
               state_in   = S_ROOT;
            end
         end
         S_ROOT: begin
            if (&visited_ff) begin
               stat.done = 1'b1;
               state_in  = S_IDLE;
            end else begin
               cur_in              = enc_idx;
               visited_in[enc_idx] = 1'b1;
               on_path_in[enc_idx] = 1'b1;
               mat_rd_en           = 1'b1;
               mat_rd_addr         = enc_idx;
               state_in            = S_EVAL;
            end
         end
         S_EVAL: begin
            if (hit) begin
               // back edge to a node on the current path
               stat.done  = 1'b1;
               stat.found = 1'b1;
               state_in   = S_IDLE;
            end else if (|cand) begin
               stk_wr_en           = 1'b1;
               depth_in            = depth_ff + NW'(1);
               cur_in              = enc_idx;
               visited_in[enc_idx] = 1'b1;
               on_path_in[enc_idx] = 1'b1;
               mat_rd_en           = 1'b1;
               mat_rd_addr         = enc_idx;
            end else begin
               on_path_in[cur_ff] = 1'b0;
               if (depth_ff == '0) begin
                  state_in = S_ROOT;
               end else begin
                  stk_rd_en = 1'b1;
                  depth_in  = depth_ff - NW'(1);
                  state_in  = S_POP;
               end
            end
         end
         S_POP: begin
            cur_in      = stk_rd_data;
            mat_rd_en   = 1'b1;
            mat_rd_addr = stk_rd_data;
            state_in    = S_EVAL;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         visited_ff <= '0;
         on_path_ff <= '0;
         depth_ff   <= '0;
      end else begin
         state_ff   <= state_in;
         visited_ff <= visited_in;
         on_path_ff <= on_path_in;
         depth_ff   <= depth_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

endmodule

`default_nettype wire

### rtl/core/wait_for_graph_cycle_detect.sv
// ----------------------------------------------------------------------------
// wait_for_graph_cycle_detect
// Deadlock detector over a wait-for graph held as an adjacency matrix in RAM.
// Flow: add reads the source row, then writes it back with the new edge bit;
//   clear, unused op and out-of-range add go straight to the result; check
//   runs a DFS that reads a matrix row per step and the stack on each return.
// Throughput: one transaction in flight; the next is taken once the result
//   is registered, while that result waits at the output.
// Reset: synchronous, clears the matrix valid bits, marks and control at once.
// ----------------------------------------------------------------------------
`default_nettype none

module wait_for_graph_cycle_detect #(
   parameter int NODES = 32
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire wfg_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output wfg_pkg::rsp_type      rsp_data
);

   localparam int NW = $clog2(NODES);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_ADD_RD = 5'b00010,
      ST_ADD_WR = 5'b00100,
      ST_CHECK  = 5'b01000,
      ST_DONE   = 5'b10000
   } top_state_type;

   top_state_type          state_ff, state_in;
   wfg_pkg::req_type       req_ff, req_in;
   logic                   found_ff, found_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   wfg_pkg::rsp_type       rsp_ff, rsp_in;

   logic                   req_acc;
   logic                   in_range;
   logic                   srch_start;
   wfg_pkg::srch_stat_type srch_stat;
   logic                   srch_rd_en;
   logic [NW-1:0]          srch_rd_addr;
   logic                   mat_clr;
   logic                   mat_rd_en;
   logic [NW-1:0]          mat_rd_addr;
   logic [NODES-1:0]       mat_rd_data;
   logic                   mat_wr_en;
   logic [NODES-1:0]       mat_wr_data;
   logic [NODES-1:0]       to_bit;

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_acc    = req_valid && req_ready;
   assign in_range   = (int'(req_data.from_node) < NODES) &&
                       (int'(req_data.to_node) < NODES);
   assign srch_start = req_acc && (req_data.op == wfg_pkg::OP_CHECK);
   assign mat_clr    = req_acc && (req_data.op == wfg_pkg::OP_CLEAR);

   always_comb begin
      to_bit                          = '0;
      to_bit[NW'(req_ff.to_node)]     = 1'b1;
   end

   assign mat_rd_en   = (state_ff == ST_ADD_RD) || srch_rd_en;
   assign mat_rd_addr = (state_ff == ST_ADD_RD) ? NW'(req_ff.from_node) : srch_rd_addr;
   assign mat_wr_en   = (state_ff == ST_ADD_WR);
   assign mat_wr_data = mat_rd_data | to_bit;

   wfg_matrix #(
      .NODES (NODES)
   ) u_matrix (
      .clock   (clock),
      .reset   (reset),
      .clr     (mat_clr),
      .rd_en   (mat_rd_en),
      .rd_addr (mat_rd_addr),
      .rd_data (mat_rd_data),
      .wr_en   (mat_wr_en),
      .wr_addr (NW'(req_ff.from_node)),
      .wr_data (mat_wr_data)
   );

   wfg_search #(
      .NODES (NODES)
   ) u_search (
      .clock       (clock),
      .reset       (reset),
      .start       (srch_start),
      .stat        (srch_stat),
      .mat_rd_en   (srch_rd_en),
      .mat_rd_addr (srch_rd_addr),
      .mat_rd_data (mat_rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      found_in     = found_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               req_in   = req_data;
               found_in = 1'b0;
               unique case (req_data.op)
                  wfg_pkg::OP_ADD:   state_in = in_range ? ST_ADD_RD : ST_DONE;
                  wfg_pkg::OP_CHECK: state_in = ST_CHECK;
                  default:           state_in = ST_DONE;
               endcase
            end
         end
         ST_ADD_RD: begin
            state_in = ST_ADD_WR;
         end
         ST_ADD_WR: begin
            state_in = ST_DONE;
         end
         ST_CHECK: begin
            if (srch_stat.done) begin
               found_in = srch_stat.found;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.cycle_found = found_ff;
               rsp_in.op_done     = req_ff.op;
               rsp_valid_in       = 1'b1;
               state_in           = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      found_ff <= found_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

### rtl/core/wfg_checker.sv
// ----------------------------------------------------------------------------
// wfg_checker
// Port-level checks for the wait-for graph cycle detector, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module wfg_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_ready,
   input wire wfg_pkg::req_type req_data,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire wfg_pkg::rsp_type rsp_data
);

   // stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // only a check may report a cycle
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.cycle_found |-> rsp_data.op_done == wfg_pkg::OP_CHECK)
      else $error("cycle reported for a non-check transaction");

   // one transaction in flight: busy right after taking one
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // a new request never completes in the cycle after it is taken
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !rsp_valid |=> !rsp_valid)
      else $error("result appeared too early");

   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind wait_for_graph_cycle_detect wfg_checker u_wfg_checker (.*);

`default_nettype wire
